### design/sound_level_rms_meter_core_macros.svh
// Assertion macros for the sound level meter. They expect clk_i and rst_ni in scope.
`ifndef SOUND_LEVEL_RMS_METER_CORE_MACROS_SVH
`define SOUND_LEVEL_RMS_METER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SRM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("srm: property violated");
`define SRM_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("srm: forbidden condition seen");
`else
`define SRM_ASSERT(label, prop)
`define SRM_ASSERT_NEVER(label, expr)
`endif
`endif

### design/srm_pkg.sv
`timescale 1ns / 1ps
package srm_pkg;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned X_W       = 22;
  localparam int unsigned Y_W       = 23;
  localparam int unsigned SQ_W      = 44;
  localparam int unsigned RMS_W     = 29;
  localparam int unsigned MEAN_W    = 2 * RMS_W;
  localparam int unsigned SPL_W     = 16;
  localparam int unsigned V_W       = 38;
  localparam int unsigned E_W       = 6;
  localparam int unsigned MANT_W    = 31;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned L2_W      = E_W + FRAC_W;
  localparam int unsigned DBP_W     = 50;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [4:0]  ALIGN_RESET  = 5'd11;
  localparam logic [3:0]  DC_RESET     = 4'd8;
  localparam logic [15:0] WINDOW_RESET = 16'd22050;
  localparam logic [15:0] OFFSET_RESET = 16'd14955;

  // About 1e-6 of full scale, in units of 2^-31.
  localparam logic [V_W-1:0] EPS_TERM = V_W'(2147);
  // 256 * 20 * log10(2) in Q16.
  localparam logic [26:0] DB_PER_LOG2 = 27'd101008905;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALIGN_SHIFT,
    CFG_DC_SHIFT,
    CFG_WINDOW_LENGTH,
    CFG_SPL_OFFSET
  } cfg_idx_e;

  typedef struct packed {
    logic full;
    logic empty;
  } srm_q_status_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } srm_back_status_t;

endpackage

### design/srm_if.sv
`timescale 1ns / 1ps
interface srm_sample_if import srm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_word;

  modport source (output valid, output sample_word, input ready);
  modport sink (input valid, input sample_word, output ready);
endinterface

interface srm_result_if import srm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [RMS_W-1:0]        rms_level;
  logic signed [SPL_W-1:0] spl_db;

  modport source (output valid, output rms_level, output spl_db, input ready);
  modport sink (input valid, input rms_level, input spl_db, output ready);
endinterface

### design/srm_front.sv
`timescale 1ns / 1ps
module srm_front import srm_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned ACC_WIDTH   = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  logic                       in_valid_i,
  input  logic signed [SAMPLE_W-1:0] sample_word_i,
  input  logic [4:0]                 align_shift_i,
  input  logic [3:0]                 dc_shift_i,
  input  logic [15:0]                window_length_i,
  output logic                       push_o,
  output logic [ACC_WIDTH-1:0]       push_sum_o,
  output logic [COUNT_WIDTH:0]       push_n_o
);

  logic                  v1_q, v2_q, v3_q;
  logic signed [X_W-1:0] x1_q, x2_q, dc_q;
  logic [SQ_W-1:0]       sq3_q;
  logic [ACC_WIDTH-1:0]  sum_q;
  logic [COUNT_WIDTH-1:0] count_q;

  logic signed [SAMPLE_W-1:0] shifted;
  logic                       ovf_hi, ovf_lo;
  logic signed [X_W-1:0]      x_sat;
  logic signed [Y_W-1:0]      diff, step, dc_sum, y;
  logic signed [2*Y_W-1:0]    sq_full;
  logic [ACC_WIDTH:0]         sum_ext;
  logic [ACC_WIDTH-1:0]       sum_new;
  logic [COUNT_WIDTH:0]       cnt1, win;
  logic [31:0]                wl32, lim32, win32;
  logic                       done;

  always_comb begin
    shifted = sample_word_i >>> align_shift_i;
    ovf_hi  = !shifted[SAMPLE_W-1] && (shifted[SAMPLE_W-2:X_W-1] != '0);
    ovf_lo  = shifted[SAMPLE_W-1] && (shifted[SAMPLE_W-2:X_W-1] != '1);
    if (ovf_hi) begin
      x_sat = {1'b0, {(X_W-1){1'b1}}};
    end else if (ovf_lo) begin
      x_sat = {1'b1, {(X_W-1){1'b0}}};
    end else begin
      x_sat = shifted[X_W-1:0];
    end

    diff   = {x1_q[X_W-1], x1_q} - {dc_q[X_W-1], dc_q};
    step   = diff >>> dc_shift_i;
    dc_sum = {dc_q[X_W-1], dc_q} + step;

    y       = {x2_q[X_W-1], x2_q} - {dc_q[X_W-1], dc_q};
    sq_full = y * y;

    sum_ext = {1'b0, sum_q} + {{(ACC_WIDTH + 1 - SQ_W){1'b0}}, sq3_q};
    sum_new = sum_ext[ACC_WIDTH] ? '1 : sum_ext[ACC_WIDTH-1:0];

    wl32  = 32'(window_length_i);
    lim32 = 32'(1) << COUNT_WIDTH;
    if (wl32 == 32'd0) begin
      win32 = 32'd1;
    end else if (wl32 > lim32) begin
      win32 = lim32;
    end else begin
      win32 = wl32;
    end
    win  = win32[COUNT_WIDTH:0];
    cnt1 = {1'b0, count_q} + (COUNT_WIDTH+1)'(1);
    done = cnt1 >= win;
  end

  assign push_o     = advance_i && v3_q && done;
  assign push_sum_o = sum_new;
  assign push_n_o   = win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      x1_q    <= '0;
      x2_q    <= '0;
      dc_q    <= '0;
      sq3_q   <= '0;
      sum_q   <= '0;
      count_q <= '0;
    end else if (advance_i) begin
      v1_q <= in_valid_i;
      x1_q <= x_sat;
      v2_q <= v1_q;
      x2_q <= x1_q;
      if (v1_q) begin
        dc_q <= dc_sum[X_W-1:0];
      end
      v3_q  <= v2_q;
      sq3_q <= sq_full[SQ_W-1:0];
      if (v3_q) begin
        if (done) begin
          sum_q   <= '0;
          count_q <= '0;
        end else begin
          sum_q   <= sum_new;
          count_q <= cnt1[COUNT_WIDTH-1:0];
        end
      end
    end
  end

endmodule

### design/srm_queue.sv
`timescale 1ns / 1ps
module srm_queue import srm_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned ACC_WIDTH   = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [ACC_WIDTH-1:0]   push_sum_i,
  input  logic [COUNT_WIDTH:0]   push_n_i,
  input  logic                   pop_i,
  output logic [ACC_WIDTH-1:0]   head_sum_o,
  output logic [COUNT_WIDTH:0]   head_n_o,
  output srm_q_status_t          status_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [ACC_WIDTH-1:0] mem_sum_q [QUEUE_DEPTH];
  logic [COUNT_WIDTH:0] mem_n_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]     fill_q;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign status_o.full  = fill_q == CNT_W'(QUEUE_DEPTH);
  assign status_o.empty = fill_q == '0;
  assign head_sum_o     = mem_sum_q[rd_ptr_q];
  assign head_n_o       = mem_n_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_sum_q[wr_ptr_q] <= push_sum_i;
      mem_n_q[wr_ptr_q]   <= push_n_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - CNT_W'(1);
      end
    end
  end

endmodule

### design/srm_back.sv
`timescale 1ns / 1ps
module srm_back import srm_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned ACC_WIDTH   = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  logic [ACC_WIDTH-1:0]    q_sum_i,
  input  logic [COUNT_WIDTH:0]    q_n_i,
  input  logic signed [15:0]      spl_offset_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [RMS_W-1:0]        out_rms_o,
  output logic signed [SPL_W-1:0] out_spl_o,
  output srm_back_status_t        status_o
);

  localparam int unsigned DVD_W = ACC_WIDTH + 16;
  localparam int unsigned REM_W = COUNT_WIDTH + 2;
  localparam int unsigned CNT_W = $clog2(DVD_W);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SQRT, S_NORM, S_LOG_MUL, S_LOG_SQ, S_DB_MUL, S_DB_ADD, S_DONE
  } state_e;

  state_e                   state_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [DVD_W-1:0]         dvd_q;
  logic [REM_W-1:0]         rem_q;
  logic [COUNT_WIDTH:0]     n_q;
  logic                     sat_q;
  logic [MEAN_W-1:0]        num_q, res_q, bit_q;
  logic [RMS_W-1:0]         rms_q;
  logic [V_W-1:0]           v_q;
  logic [E_W-1:0]           e_q;
  logic [MANT_W-1:0]        m_q;
  logic [2*MANT_W-1:0]      prod_q;
  logic [FRAC_W-1:0]        frac_q;
  logic signed [DBP_W-1:0]  dbp_q;
  logic signed [SPL_W-1:0]  spl_q;
  logic                     out_valid_q;
  logic [RMS_W-1:0]         out_rms_q;
  logic signed [SPL_W-1:0]  out_spl_q;

  logic [REM_W-1:0]         rem_sh;
  logic                     q_bit;
  logic [MEAN_W:0]          trial;
  logic [31:0]              sq_top;
  logic signed [E_W:0]      e_rel;
  logic signed [L2_W-1:0]   l2;
  logic signed [DBP_W-1:0]  dbp_d, db_round;
  logic signed [17:0]       db_q18;
  logic signed [18:0]       db_sum;
  logic signed [SPL_W-1:0]  db_sat;
  logic                     slot_free;

  always_comb begin
    rem_sh = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
    q_bit  = rem_sh >= {1'b0, n_q};
    trial  = {1'b0, res_q} + {1'b0, bit_q};
    sq_top = prod_q[2*MANT_W-1:30];
    e_rel  = $signed({1'b0, e_q}) - (E_W+1)'(31);
    l2     = {e_rel[E_W-1:0], frac_q};
    dbp_d  = l2 * $signed({1'b0, DB_PER_LOG2});
    db_round = dbp_q + DBP_W'(64'h8000_0000);
    db_q18 = db_round[DBP_W-1:32];
    db_sum = {db_q18[17], db_q18} + {{3{spl_offset_i[15]}}, spl_offset_i};
    if (db_sum[18:15] == 4'b0000 || db_sum[18:15] == 4'b1111) begin
      db_sat = db_sum[SPL_W-1:0];
    end else if (db_sum[18]) begin
      db_sat = {1'b1, {(SPL_W-1){1'b0}}};
    end else begin
      db_sat = {1'b0, {(SPL_W-1){1'b1}}};
    end
    slot_free = !out_valid_q || out_ready_i;
  end

  assign status_o.busy = state_q != S_IDLE;
  assign status_o.pop  = (state_q == S_IDLE) && q_valid_i;
  assign out_valid_o   = out_valid_q;
  assign out_rms_o     = out_rms_q;
  assign out_spl_o     = out_spl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      dvd_q       <= '0;
      rem_q       <= '0;
      n_q         <= '0;
      sat_q       <= 1'b0;
      num_q       <= '0;
      res_q       <= '0;
      bit_q       <= '0;
      rms_q       <= '0;
      v_q         <= '0;
      e_q         <= '0;
      m_q         <= '0;
      prod_q      <= '0;
      frac_q      <= '0;
      dbp_q       <= '0;
      spl_q       <= '0;
      out_valid_q <= 1'b0;
      out_rms_q   <= '0;
      out_spl_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            dvd_q   <= {q_sum_i, 16'b0};
            n_q     <= q_n_i;
            rem_q   <= '0;
            cnt_q   <= CNT_W'(DVD_W - 1);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= q_bit ? rem_sh - {1'b0, n_q} : rem_sh;
          dvd_q <= {dvd_q[DVD_W-2:0], q_bit};
          if (cnt_q == '0) begin
            state_q <= S_SQRT;
            cnt_q   <= CNT_W'(RMS_W - 1);
            sat_q   <= 1'b0;
            num_q   <= {dvd_q[MEAN_W-2:0], q_bit};
            res_q   <= '0;
            bit_q   <= MEAN_W'(1) << (MEAN_W - 2);
            if (dvd_q[DVD_W-2:MEAN_W-1] != '0) begin
              sat_q <= 1'b1;
            end
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        S_SQRT: begin
          if ({1'b0, num_q} >= trial) begin
            num_q <= num_q - trial[MEAN_W-1:0];
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (cnt_q == '0) begin
            state_q <= S_NORM;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        S_NORM: begin
          if (v_q == '0) begin
            rms_q <= sat_q ? '1 : res_q[RMS_W-1:0];
            v_q   <= {(sat_q ? {RMS_W{1'b1}} : res_q[RMS_W-1:0]), 8'b0} + EPS_TERM;
            e_q   <= E_W'(V_W - 1);
          end else if (!v_q[V_W-1]) begin
            v_q <= v_q << 1;
            e_q <= e_q - E_W'(1);
          end else begin
            m_q     <= v_q[V_W-1:V_W-MANT_W];
            frac_q  <= '0;
            cnt_q   <= CNT_W'(FRAC_W - 1);
            state_q <= S_LOG_MUL;
          end
        end
        S_LOG_MUL: begin
          prod_q  <= m_q * m_q;
          state_q <= S_LOG_SQ;
        end
        S_LOG_SQ: begin
          frac_q <= {frac_q[FRAC_W-2:0], sq_top[31]};
          m_q    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
          if (cnt_q == '0) begin
            state_q <= S_DB_MUL;
          end else begin
            cnt_q   <= cnt_q - CNT_W'(1);
            state_q <= S_LOG_MUL;
          end
        end
        S_DB_MUL: begin
          dbp_q   <= dbp_d;
          v_q     <= '0;
          state_q <= S_DB_ADD;
        end
        S_DB_ADD: begin
          spl_q   <= db_sat;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_rms_q   <= rms_q;
            out_spl_q   <= spl_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/sound_level_rms_meter_core.sv
`timescale 1ns / 1ps
// Windowed RMS and sound pressure level meter. Each transaction on sample_i carries one
// raw 32-bit microphone word; it is aligned, DC-corrected, squared and summed by a
// four-stage front end that takes one sample every clock cycle while the queue has
// room. When a window of window_length samples is complete, the sum goes into a
// two-entry queue and a sequential back end works out the mean (bit-serial divider),
// the square root, the base-2 logarithm (a normalising shift and 16 squaring rounds,
// each a multiply state and a squaring state) and the scaling to 1/256 dB. One
// transaction on result_o follows per window, held in an output register, so the front
// end keeps running while one result waits. Windows shorter than the back-end time, or
// results that are not taken, fill both queue entries and then hold sample_i.ready low.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i, and should only
// change while the meter is idle.
`include "sound_level_rms_meter_core_macros.svh"
module sound_level_rms_meter_core import srm_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned ACC_WIDTH   = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  srm_sample_if.sink            sample_i,
  srm_result_if.source          result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers, loaded with their documented reset values.
  logic [4:0]         align_shift_q;
  logic [3:0]         dc_shift_q;
  logic [15:0]        window_length_q;
  logic signed [15:0] spl_offset_q;

  logic                 push;
  logic [ACC_WIDTH-1:0] push_sum, head_sum;
  logic [COUNT_WIDTH:0] push_n, head_n;
  srm_q_status_t        q_stat;
  srm_back_status_t     back_stat;
  logic                 advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_shift_q   <= ALIGN_RESET;
      dc_shift_q      <= DC_RESET;
      window_length_q <= WINDOW_RESET;
      spl_offset_q    <= OFFSET_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ALIGN_SHIFT:   align_shift_q   <= cfg_data_i[4:0];
        CFG_DC_SHIFT:      dc_shift_q      <= cfg_data_i[3:0];
        CFG_WINDOW_LENGTH: window_length_q <= cfg_data_i;
        CFG_SPL_OFFSET:    spl_offset_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The whole front pipeline moves together; it only waits when the queue is full.
  assign advance        = !q_stat.full;
  assign sample_i.ready = advance;

  srm_front #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .in_valid_i     (sample_i.valid),
    .sample_word_i  (sample_i.sample_word),
    .align_shift_i  (align_shift_q),
    .dc_shift_i     (dc_shift_q),
    .window_length_i(window_length_q),
    .push_o         (push),
    .push_sum_o     (push_sum),
    .push_n_o       (push_n)
  );

  srm_queue #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_sum_i(push_sum),
    .push_n_i  (push_n),
    .pop_i     (back_stat.pop),
    .head_sum_o(head_sum),
    .head_n_o  (head_n),
    .status_o  (q_stat)
  );

  srm_back #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (!q_stat.empty),
    .q_sum_i     (head_sum),
    .q_n_i       (head_n),
    .spl_offset_i(spl_offset_q),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .out_rms_o   (result_o.rms_level),
    .out_spl_o   (result_o.spl_db),
    .status_o    (back_stat)
  );

  // A finished window must never be written into a full queue.
  `SRM_ASSERT_NEVER(a_push_when_full, push && q_stat.full)
  // The back end only takes a window that is really there.
  `SRM_ASSERT_NEVER(a_pop_when_empty, back_stat.pop && q_stat.empty)
  // A new result only appears at the end of a back-end run.
  `SRM_ASSERT(a_result_from_back, $rose(result_o.valid) |-> $past(back_stat.busy))

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the RMS and SPL meter. The bench keeps its own model of the
// meter to predict each window result.
module tb;
  import srm_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_idx_e cfg_idx_i = CFG_ALIGN_SHIFT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  srm_sample_if s_if ();
  srm_result_if r_if ();

  sound_level_rms_meter_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (s_if),
    .result_o   (r_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // One window result as the meter should give it.
  typedef struct {
    logic [RMS_W-1:0]        rms;
    logic signed [SPL_W-1:0] spl;
  } level_t;

  level_t levels_due[$];

  // Mirror of the configuration registers and of the meter's running state.
  logic [4:0]         align_m;
  logic [3:0]         dcs_m;
  logic [15:0]        win_m;
  logic signed [15:0] off_m;
  longint             dc_m;
  longint unsigned    sum_m;
  int unsigned        count_m;

  int errors = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  // Values typed into the directed table override the computed ones for one result.
  bit force_rms = 0, force_spl = 0;
  logic [RMS_W-1:0] forced_rms;
  logic signed [SPL_W-1:0] forced_spl;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint log2_fix(input longint unsigned v);
    int e;
    longint unsigned m;
    longint fr;
    e = 0;
    fr = 0;
    while (e < 63 && (v >> (e + 1)) != 0) e++;
    m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      fr <<= 1;
      if (m >= (64'd1 << 31)) begin
        fr |= 1;
        m >>= 1;
      end
    end
    return longint'(e) * 65536 + fr;
  endfunction

  // Advances the mirrored meter by one sample; true when a window closes.
  function automatic bit meter_sample(input logic [31:0] word, output level_t lv);
    longint x, dc, y, l2, db;
    longint unsigned sq, win, q, r, mean, rms;
    x = longint'($signed(word)) >>> align_m;
    if (x > 2097151) x = 2097151;
    if (x < -2097152) x = -2097152;
    dc = dc_m + ((x - dc_m) >>> dcs_m);
    dc_m = dc;
    y = x - dc;
    sq = longint'(y * y);
    if (sum_m > ~64'd0 - sq) sum_m = ~64'd0;
    else sum_m += sq;
    win = (win_m == 0) ? 1 : win_m;
    if (count_m + 1 < win) begin
      count_m++;
      return 1'b0;
    end
    q = sum_m / win;
    r = sum_m % win;
    mean = (q >= (64'd1 << 48)) ? ~64'd0 : (q << 16) + ((r << 16) / win);
    rms = int_sqrt(mean);
    if (rms > 64'd536870911) rms = 64'd536870911;
    l2 = log2_fix(rms * 256 + 2147) - longint'(31) * 65536;
    db = (l2 * 101008905 + 64'sd2147483648) >>> 32;
    db += off_m;
    if (db > 32767) db = 32767;
    if (db < -32768) db = -32768;
    lv.rms = rms[RMS_W-1:0];
    lv.spl = db[15:0];
    sum_m = 0;
    count_m = 0;
    return 1'b1;
  endfunction

  // Every accepted sample transaction goes through the mirror.
  always @(posedge clk_i) begin
    level_t lv;
    if (rst_ni && s_if.valid && s_if.ready) begin
      if (meter_sample(s_if.sample_word, lv)) begin
        if (force_rms) lv.rms = forced_rms;
        if (force_spl) lv.spl = forced_spl;
        levels_due.push_back(lv);
      end
    end
  end

  // Result transactions are checked against the oldest level still due.
  always @(posedge clk_i) begin
    level_t lv;
    if (rst_ni && r_if.valid && r_if.ready) begin
      if (levels_due.size() == 0) begin
        report_mismatch("unexpected result, rms", r_if.rms_level, -1);
      end else begin
        lv = levels_due.pop_front();
        if (r_if.rms_level !== lv.rms) report_mismatch("rms_level", r_if.rms_level, lv.rms);
        if (r_if.spl_db !== lv.spl) report_mismatch("spl_db", r_if.spl_db, lv.spl);
      end
    end
  end

  // Result side: random stalls, and a long hold-off on request.
  initial begin
    int n;
    r_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        r_if.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_req = 1'b0;
      end
      n = idle_on ? $urandom_range(0, 9) : 0;
      if (n > 0) begin
        r_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      r_if.ready <= 1'b1;
      while (!(r_if.valid && r_if.ready)) @(posedge clk_i);
    end
  end

  // Watchdog: ends the run when no transaction has moved for too long.
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((s_if.valid && s_if.ready) || (r_if.valid && r_if.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 10000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ALIGN_SHIFT:   align_m = data[4:0];
      CFG_DC_SHIFT:      dcs_m = data[3:0];
      CFG_WINDOW_LENGTH: win_m = data;
      default:           off_m = data;
    endcase
  endtask

  // Waits for every due result, then lets the back end drain before any write.
  task automatic drain();
    s_if.valid <= 1'b0;
    @(posedge clk_i);
    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_meter(input int al, input int ds, input int wl, input int of);
    write_reg(CFG_ALIGN_SHIFT, 16'(al));
    write_reg(CFG_DC_SHIFT, 16'(ds));
    write_reg(CFG_WINDOW_LENGTH, 16'(wl));
    write_reg(CFG_SPL_OFFSET, 16'(of));
  endtask

  task automatic send_sample(input logic [31:0] word);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_if.valid <= 1'b1;
    s_if.sample_word <= word;
    do @(posedge clk_i); while (!s_if.ready);
  endtask

  function automatic logic [31:0] rand_word();
    int unsigned sel;
    sel = $urandom_range(0, 3);
    if (sel == 0) return $urandom_range(0, 8191) - 4096;
    if (sel == 1) return ($urandom_range(0, 8191) - 4096) <<< 11;
    return $urandom;
  endfunction

  typedef struct {
    int align, dcs, win, off;
    logic [31:0] word;
    bit chk_rms, chk_spl;
    int rms, spl;
  } row_t;

  // Directed rows use a window of one sample (window register zero or one), so every row
  // gives one result. A zero leak shift makes the DC level follow the sample exactly.
  row_t rows[] = '{
    '{11, 0, 0, 0, 32'h0000_0000, 1, 0, 0, 0},
    '{11, 0, 0, -32768, 32'h7fff_ffff, 1, 1, 0, -32768},
    '{11, 0, 0, 32767, 32'h8000_0000, 1, 0, 0, 0},
    // Sample far from the DC level: the RMS and then the SPL saturate.
    '{0, 15, 0, 32767, 32'h7fff_ffff, 1, 1, 536870911, 32767},
    '{0, 15, 0, 32767, 32'h8000_0000, 0, 0, 0, 0},
    '{0, 1, 0, 0, 32'h0000_0001, 0, 0, 0, 0},
    '{0, 1, 0, 0, 32'hffff_ffff, 0, 0, 0, 0},
    '{31, 1, 0, 0, 32'h8000_0000, 0, 0, 0, 0},
    '{31, 1, 0, 0, 32'h7fff_ffff, 0, 0, 0, 0},
    '{16, 15, 0, -32768, 32'h1234_5678, 0, 0, 0, 0},
    '{16, 15, 0, -32768, 32'hedcb_a988, 0, 0, 0, 0},
    '{5, 4, 1, 14955, 32'h0005_5555, 0, 0, 0, 0},
    '{5, 4, 1, 14955, 32'hfffa_aaaa, 0, 0, 0, 0},
    '{11, 8, 0, 100, 32'h00ff_ff00, 0, 0, 0, 0}
  };

  initial begin
    int sent, n;
    align_m = ALIGN_RESET;
    dcs_m = DC_RESET;
    win_m = WINDOW_RESET;
    off_m = OFFSET_RESET;
    dc_m = 0;
    sum_m = 0;
    count_m = 0;
    s_if.valid = 1'b0;
    s_if.sample_word = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      drain();
      set_meter(rows[i].align, rows[i].dcs, rows[i].win, rows[i].off);
      force_rms = rows[i].chk_rms;
      force_spl = rows[i].chk_spl;
      forced_rms = RMS_W'(rows[i].rms);
      forced_spl = SPL_W'(rows[i].spl);
      send_sample(rows[i].word);
      s_if.valid <= 1'b0;
      @(posedge clk_i);
      force_rms = 0;
      force_spl = 0;
    end

    // Back end congestion: results are held off while samples keep arriving.
    drain();
    set_meter(11, 8, 0, 0);
    idle_on = 1'b0;
    hold_req = 1'b1;
    repeat (30) send_sample(rand_word());
    idle_on = 1'b1;

    // Random phases. A phase can end mid-window, so a later, shorter window
    // closes on the next sample.
    sent = 0;
    while (sent < 880) begin
      drain();
      n = $urandom_range(0, 3);
      set_meter($urandom_range(0, 31), $urandom_range(0, 15),
                (n == 0) ? 0 : (n == 1) ? 64 : $urandom_range(1, 40),
                $urandom_range(0, 65535));
      idle_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(20, 120);
      repeat (n) send_sample(rand_word());
      sent += n;
    end

    // A full window streamed without gaps.
    drain();
    set_meter(16, 1, 64, 32767);
    idle_on = 1'b0;
    repeat (64) send_sample(rand_word());
    idle_on = 1'b1;

    drain();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
